// File: sv/csat_pkg.sv
// Package: constants, codes and shared types of the chunk store allocator.
package csat_pkg;

	localparam int MAX_FILES    = 16;
	localparam int MAX_CHUNKS   = 1024;
	localparam int SPILL_CHUNKS = 4096;
	localparam int MAX_SEGMENTS = 64;

	localparam int FILE_W   = $clog2(MAX_FILES);
	localparam int CHUNK_W  = $clog2(MAX_CHUNKS);
	localparam int COUNT_W  = $clog2(MAX_CHUNKS + 1);
	localparam int SPILL_W  = $clog2(SPILL_CHUNKS);
	localparam int STOP_W   = $clog2(SPILL_CHUNKS + 1);
	localparam int PHYS_W   = (SPILL_W > CHUNK_W) ? SPILL_W : CHUNK_W;
	localparam int MAP_AW   = FILE_W + CHUNK_W;
	localparam int MAP_DEPTH = MAX_FILES * MAX_CHUNKS;
	localparam int SEG_W    = $clog2(MAX_SEGMENTS);

	localparam logic [1:0] LOC_NONE  = 2'd0;
	localparam logic [1:0] LOC_MEM   = 2'd1;
	localparam logic [1:0] LOC_SPILL = 2'd2;

	localparam logic [1:0] OP_EXTEND = 2'd0;
	localparam logic [1:0] OP_SHRINK = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_WRITE  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_IOERR   = 2'd2;
	localparam logic [1:0] ST_TOOMANY = 2'd3;

	localparam logic [1:0] CFG_SIZE_LOG2 = 2'd0;
	localparam logic [1:0] CFG_MEM_EN    = 2'd1;
	localparam logic [1:0] CFG_SPILL_EN  = 2'd2;

	localparam logic [4:0] SIZE_LOG2_MIN = 5'd4;
	localparam logic [4:0] SIZE_LOG2_MAX = 5'd20;
	localparam logic [4:0] SIZE_LOG2_RST = 5'd16;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [MAP_AW-1:0] addr;
		logic [1:0]        wr_loc;
		logic [PHYS_W-1:0] wr_phys;
	} map_req_t;

	typedef struct packed {
		logic              pop_mem;
		logic              pop_spill;
		logic              push_mem;
		logic              push_spill;
		logic [PHYS_W-1:0] push_data;
	} pool_req_t;

	typedef struct packed {
		logic              init_done;
		logic [COUNT_W-1:0] mem_top;
		logic [STOP_W-1:0] spill_top;
		logic [PHYS_W-1:0] rd_data;
	} pool_sts_t;

endpackage

// File: sv/csat_if.sv
// Channel interfaces: request, response and configuration write.
interface csat_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  file_id;
	logic [30:0] byte_position;
	logic [30:0] byte_count;
	modport source(output valid, op, file_id, byte_position, byte_count, input ready);
	modport sink(input valid, op, file_id, byte_position, byte_count, output ready);
endinterface

interface csat_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        in_spill;
	logic [31:0] phys_address;
	logic [20:0] segment_bytes;
	logic [30:0] buffer_offset;
	logic        is_write;
	logic        last;
	modport source(output valid, status, in_spill, phys_address, segment_bytes,
		buffer_offset, is_write, last, input ready);
	modport sink(input valid, status, in_spill, phys_address, segment_bytes,
		buffer_offset, is_write, last, output ready);
endinterface

interface csat_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [4:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/csat_map.sv
// Chunk map: location and physical id per file chunk, with clear pass after reset.
module csat_map (
	input  logic                           clk,
	input  logic                           arst_n,
	input  csat_pkg::map_req_t             req,
	output logic [1:0]                     rd_loc,
	output logic [csat_pkg::PHYS_W-1:0]    rd_phys,
	output logic                           init_done
);
	logic [1:0]                  loc_mem  [csat_pkg::MAP_DEPTH];
	logic [csat_pkg::PHYS_W-1:0] phys_mem [csat_pkg::MAP_DEPTH];
	logic [csat_pkg::MAP_AW:0]   clr_q;

	assign init_done = clr_q[csat_pkg::MAP_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!init_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!init_done) begin
			loc_mem[clr_q[csat_pkg::MAP_AW-1:0]] <= csat_pkg::LOC_NONE;
		end else if (req.wr_en) begin
			loc_mem[req.addr] <= req.wr_loc;
		end
	end

	always_ff @(posedge clk) begin
		if (init_done && req.wr_en) begin
			phys_mem[req.addr] <= req.wr_phys;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_loc  <= loc_mem[req.addr];
			rd_phys <= phys_mem[req.addr];
		end
	end
endmodule

// File: sv/csat_pool.sv
// Free chunk stacks of the memory and spill pools, filled after reset.
module csat_pool (
	input  logic                clk,
	input  logic                arst_n,
	input  csat_pkg::pool_req_t req,
	output csat_pkg::pool_sts_t sts
);
	logic [csat_pkg::CHUNK_W-1:0] mem_stk   [csat_pkg::MAX_CHUNKS];
	logic [csat_pkg::SPILL_W-1:0] spill_stk [csat_pkg::SPILL_CHUNKS];
	logic [csat_pkg::COUNT_W-1:0] mem_top_q;
	logic [csat_pkg::STOP_W-1:0]  spill_top_q;
	logic [csat_pkg::STOP_W-1:0]  init_q;
	logic [csat_pkg::CHUNK_W-1:0] mem_rd_q;
	logic [csat_pkg::SPILL_W-1:0] spill_rd_q;
	logic                         sel_spill_q;
	logic                         init_done;
	logic                         mem_push_ok, spill_push_ok;
	logic [csat_pkg::CHUNK_W-1:0] mem_pop_idx;
	logic [csat_pkg::SPILL_W-1:0] spill_pop_idx;

	assign init_done     = (init_q == csat_pkg::STOP_W'(csat_pkg::SPILL_CHUNKS));
	assign mem_push_ok   = req.push_mem &&
		(mem_top_q < csat_pkg::COUNT_W'(csat_pkg::MAX_CHUNKS));
	assign spill_push_ok = req.push_spill &&
		(spill_top_q < csat_pkg::STOP_W'(csat_pkg::SPILL_CHUNKS));
	assign mem_pop_idx   = csat_pkg::CHUNK_W'(mem_top_q - 1'b1);
	assign spill_pop_idx = csat_pkg::SPILL_W'(spill_top_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= '0;
			mem_top_q   <= csat_pkg::COUNT_W'(csat_pkg::MAX_CHUNKS);
			spill_top_q <= csat_pkg::STOP_W'(csat_pkg::SPILL_CHUNKS);
			sel_spill_q <= 1'b0;
		end else begin
			if (!init_done) init_q <= init_q + 1'b1;
			if (req.pop_mem) begin
				mem_top_q   <= mem_top_q - 1'b1;
				sel_spill_q <= 1'b0;
			end else if (mem_push_ok) begin
				mem_top_q <= mem_top_q + 1'b1;
			end
			if (req.pop_spill) begin
				spill_top_q <= spill_top_q - 1'b1;
				sel_spill_q <= 1'b1;
			end else if (spill_push_ok) begin
				spill_top_q <= spill_top_q + 1'b1;
			end
		end
	end

	// stack entry i holds id DEPTH-1-i, so ids leave in ascending order
	always_ff @(posedge clk) begin
		if (!init_done) begin
			if (init_q < csat_pkg::STOP_W'(csat_pkg::MAX_CHUNKS)) begin
				mem_stk[init_q[csat_pkg::CHUNK_W-1:0]] <=
					csat_pkg::CHUNK_W'(csat_pkg::MAX_CHUNKS - 1) -
					init_q[csat_pkg::CHUNK_W-1:0];
			end
		end else if (mem_push_ok) begin
			mem_stk[mem_top_q[csat_pkg::CHUNK_W-1:0]] <=
				req.push_data[csat_pkg::CHUNK_W-1:0];
		end
		if (req.pop_mem) mem_rd_q <= mem_stk[mem_pop_idx];
	end

	always_ff @(posedge clk) begin
		if (!init_done) begin
			spill_stk[init_q[csat_pkg::SPILL_W-1:0]] <=
				csat_pkg::SPILL_W'(csat_pkg::SPILL_CHUNKS - 1) -
				init_q[csat_pkg::SPILL_W-1:0];
		end else if (spill_push_ok) begin
			spill_stk[spill_top_q[csat_pkg::SPILL_W-1:0]] <=
				req.push_data[csat_pkg::SPILL_W-1:0];
		end
		if (req.pop_spill) spill_rd_q <= spill_stk[spill_pop_idx];
	end

	always_comb begin
		sts.init_done = init_done;
		sts.mem_top   = mem_top_q;
		sts.spill_top = spill_top_q;
		sts.rd_data   = sel_spill_q ? csat_pkg::PHYS_W'(spill_rd_q)
		                            : csat_pkg::PHYS_W'(mem_rd_q);
	end
endmodule

// File: sv/chunk_store_allocator_translator_top.sv
// Top level: config registers, chunk counts and the item sequencer.
// Extend allocates one chunk per pass through S_EXT and S_EXT_WR; shrink frees one per S_SHR and S_SHR_FREE.
// Access: each segment steps through map read, check, result and advance, one item at a time.
// Each step goes through the single map memory port and the stack ports.
// Reset is asynchronous active low; afterwards a clear pass over all 16384 entries of
// the chunk map runs and no item is taken until it ends (config writes are taken).
module chunk_store_allocator_translator_top (
	input logic        clk,
	input logic        arst_n,
	csat_cfg_if.sink   cfg,
	csat_req_if.sink   req,
	csat_rsp_if.source rsp
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_EXT      = 4'd1;
	localparam logic [3:0] S_EXT_WR   = 4'd2;
	localparam logic [3:0] S_SHR      = 4'd3;
	localparam logic [3:0] S_SHR_FREE = 4'd4;
	localparam logic [3:0] S_ACC      = 4'd5;
	localparam logic [3:0] S_ACC_CHK  = 4'd6;
	localparam logic [3:0] S_ACC_NXT  = 4'd7;
	localparam logic [3:0] S_OUT      = 4'd8;

	logic [3:0] state_q, ret_q;
	logic [4:0] size_log2_q;
	logic       mem_en_q, spill_en_q;
	logic [csat_pkg::COUNT_W-1:0] count_q [csat_pkg::MAX_FILES];

	logic [csat_pkg::FILE_W-1:0] fid_q;
	logic [30:0] pos_q, cnt_q, done_q;
	logic [26:0] cid_q;
	logic [27:0] keep_q;
	logic [20:0] coff_q, seg_q;
	logic [4:0]  bits_q;
	logic        wr_q, alloc_spill_q;
	logic [csat_pkg::SEG_W-1:0] n_q;

	// pending result
	logic [1:0]  r_status_q;
	logic        r_spill_q, r_last_q;
	logic [31:0] r_phys_q;
	logic [20:0] r_seg_q;
	logic [30:0] r_boff_q;

	logic        o_valid_q;
	logic [1:0]  o_status_q;
	logic        o_spill_q, o_wr_q, o_last_q;
	logic [31:0] o_phys_q;
	logic [20:0] o_seg_q;
	logic [30:0] o_boff_q;

	csat_pkg::map_req_t  map_req;
	csat_pkg::pool_req_t pool_req;
	csat_pkg::pool_sts_t pool_sts;
	logic [1:0]  map_loc;
	logic [csat_pkg::PHYS_W-1:0] map_phys;
	logic        map_done;

	logic [4:0]  bits_in;
	logic [20:0] csize_in, csize;
	logic [csat_pkg::COUNT_W-1:0] cnt_cur;
	logic [31:0] have;
	logic        more, out_free, mapped;
	logic [30:0] done_nxt, rem;
	logic [31:0] phys_addr;

	csat_map u_map (
		.clk(clk), .arst_n(arst_n), .req(map_req),
		.rd_loc(map_loc), .rd_phys(map_phys), .init_done(map_done)
	);

	csat_pool u_pool (.clk(clk), .arst_n(arst_n), .req(pool_req), .sts(pool_sts));

	always_comb begin
		bits_in = size_log2_q;
		if (bits_in < csat_pkg::SIZE_LOG2_MIN) bits_in = csat_pkg::SIZE_LOG2_MIN;
		if (bits_in > csat_pkg::SIZE_LOG2_MAX) bits_in = csat_pkg::SIZE_LOG2_MAX;
	end

	assign csize_in  = 21'd1 << bits_in;
	assign csize     = 21'd1 << bits_q;
	assign cnt_cur   = count_q[fid_q];
	assign have      = 32'(cnt_cur) << bits_q;
	assign more      = (32'(done_q) + 32'(seg_q)) < 32'(cnt_q);
	assign done_nxt  = done_q + 31'(seg_q);
	assign rem       = cnt_q - done_nxt;
	assign phys_addr = (32'(map_phys) << bits_q) + 32'(coff_q);
	assign mapped    = (map_loc == csat_pkg::LOC_MEM) || (map_loc == csat_pkg::LOC_SPILL);
	assign out_free  = !o_valid_q || rsp.ready;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE) && map_done && pool_sts.init_done;

	always_comb begin
		map_req  = '0;
		pool_req = '0;
		case (state_q)
			S_EXT: begin
				if (!(have >= 32'(pos_q)) &&
				    cnt_cur < csat_pkg::COUNT_W'(csat_pkg::MAX_CHUNKS)) begin
					if (mem_en_q && pool_sts.mem_top != '0) pool_req.pop_mem = 1'b1;
					else if (spill_en_q && pool_sts.spill_top != '0)
						pool_req.pop_spill = 1'b1;
				end
			end
			S_EXT_WR: begin
				map_req.wr_en   = 1'b1;
				map_req.addr    = {fid_q, cnt_cur[csat_pkg::CHUNK_W-1:0]};
				map_req.wr_loc  = alloc_spill_q ? csat_pkg::LOC_SPILL : csat_pkg::LOC_MEM;
				map_req.wr_phys = pool_sts.rd_data;
			end
			S_SHR: begin
				map_req.rd_en = 28'(cnt_cur) > keep_q;
				map_req.addr  = {fid_q, csat_pkg::CHUNK_W'(cnt_cur - 1'b1)};
			end
			S_SHR_FREE: begin
				map_req.addr      = {fid_q, cnt_cur[csat_pkg::CHUNK_W-1:0]};
				map_req.wr_en     = mapped;
				map_req.wr_loc    = csat_pkg::LOC_NONE;
				map_req.wr_phys   = map_phys;
				pool_req.push_mem   = (map_loc == csat_pkg::LOC_MEM);
				pool_req.push_spill = (map_loc == csat_pkg::LOC_SPILL);
				pool_req.push_data  = map_phys;
			end
			S_ACC: begin
				map_req.rd_en = (cid_q[26:csat_pkg::CHUNK_W] == '0);
				map_req.addr  = {fid_q, cid_q[csat_pkg::CHUNK_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= csat_pkg::SIZE_LOG2_RST;
			mem_en_q    <= 1'b1;
			spill_en_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				csat_pkg::CFG_SIZE_LOG2: size_log2_q <= cfg.data;
				csat_pkg::CFG_MEM_EN:    mem_en_q    <= cfg.data[0];
				csat_pkg::CFG_SPILL_EN:  spill_en_q  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			o_valid_q <= 1'b0;
			for (int i = 0; i < csat_pkg::MAX_FILES; i++) count_q[i] <= '0;
		end else begin
			if (rsp.ready && state_q != S_OUT) o_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						fid_q    <= req.file_id;
						pos_q    <= req.byte_position;
						cnt_q    <= req.byte_count;
						bits_q   <= bits_in;
						wr_q     <= (req.op == csat_pkg::OP_WRITE);
						done_q   <= '0;
						n_q      <= '0;
						cid_q    <= 27'(req.byte_position >> bits_in);
						coff_q   <= 21'(req.byte_position) & (csize_in - 1'b1);
						keep_q   <= (req.byte_position == '0) ? 28'd0 :
							28'(req.byte_position >> bits_in) + 28'd1;
						if (32'(req.byte_count) <=
						    32'(csize_in - (21'(req.byte_position) & (csize_in - 1'b1))))
							seg_q <= 21'(req.byte_count);
						else
							seg_q <= csize_in - (21'(req.byte_position) & (csize_in - 1'b1));
						case (req.op)
							csat_pkg::OP_EXTEND: state_q <= S_EXT;
							csat_pkg::OP_SHRINK: state_q <= S_SHR;
							default:             state_q <= S_ACC;
						endcase
					end
				end
				S_EXT: begin
					r_spill_q <= 1'b0; r_phys_q <= '0; r_seg_q <= '0; r_boff_q <= '0;
					r_last_q  <= 1'b1;
					ret_q     <= S_IDLE;
					if (have >= 32'(pos_q)) begin
						r_status_q <= csat_pkg::ST_OK;
						state_q    <= S_OUT;
					end else if (pool_req.pop_mem || pool_req.pop_spill) begin
						alloc_spill_q <= pool_req.pop_spill;
						state_q       <= S_EXT_WR;
					end else begin
						r_status_q <= csat_pkg::ST_NOSPACE;
						state_q    <= S_OUT;
					end
				end
				S_EXT_WR: begin
					count_q[fid_q] <= cnt_cur + 1'b1;
					state_q        <= S_EXT;
				end
				S_SHR: begin
					if (map_req.rd_en) begin
						count_q[fid_q] <= cnt_cur - 1'b1;
						state_q        <= S_SHR_FREE;
					end else begin
						r_status_q <= csat_pkg::ST_OK;
						r_spill_q <= 1'b0; r_phys_q <= '0; r_seg_q <= '0; r_boff_q <= '0;
						r_last_q  <= 1'b1;
						ret_q     <= S_IDLE;
						state_q   <= S_OUT;
					end
				end
				S_SHR_FREE: state_q <= S_SHR;
				S_ACC: begin
					if (map_req.rd_en) begin
						state_q <= S_ACC_CHK;
					end else begin
						r_status_q <= csat_pkg::ST_IOERR;
						r_spill_q <= 1'b0; r_phys_q <= '0; r_seg_q <= '0;
						r_boff_q  <= done_q;
						r_last_q  <= 1'b1;
						ret_q     <= S_IDLE;
						state_q   <= S_OUT;
					end
				end
				S_ACC_CHK: begin
					r_boff_q <= done_q;
					state_q  <= S_OUT;
					if (!mapped || (more && n_q == csat_pkg::SEG_W'(csat_pkg::MAX_SEGMENTS - 1)))
					begin
						r_status_q <= mapped ? csat_pkg::ST_TOOMANY : csat_pkg::ST_IOERR;
						r_spill_q <= 1'b0; r_phys_q <= '0; r_seg_q <= '0;
						r_last_q  <= 1'b1;
						ret_q     <= S_IDLE;
					end else begin
						r_status_q <= csat_pkg::ST_OK;
						r_spill_q  <= (map_loc == csat_pkg::LOC_SPILL);
						r_phys_q   <= phys_addr;
						r_seg_q    <= seg_q;
						r_last_q   <= !more;
						ret_q      <= more ? S_ACC_NXT : S_IDLE;
					end
				end
				S_ACC_NXT: begin
					done_q  <= done_nxt;
					cid_q   <= cid_q + 1'b1;
					coff_q  <= '0;
					n_q     <= n_q + 1'b1;
					seg_q   <= (32'(rem) > 32'(csize)) ? csize : 21'(rem);
					state_q <= S_ACC;
				end
				S_OUT: begin
					if (out_free) begin
						o_valid_q  <= 1'b1;
						o_status_q <= r_status_q;
						o_spill_q  <= r_spill_q;
						o_phys_q   <= r_phys_q;
						o_seg_q    <= r_seg_q;
						o_boff_q   <= r_boff_q;
						// only write accesses set wr_q; extend and shrink report zero
						o_wr_q     <= wr_q;
						o_last_q   <= r_last_q;
						state_q    <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = o_valid_q;
	assign rsp.status        = o_status_q;
	assign rsp.in_spill      = o_spill_q;
	assign rsp.phys_address  = o_phys_q;
	assign rsp.segment_bytes = o_seg_q;
	assign rsp.buffer_offset = o_boff_q;
	assign rsp.is_write      = o_wr_q;
	assign rsp.last          = o_last_q;
endmodule

// File: sim/csat_checker.sv
// Checker: predicts chunk allocation and address translation, compares responses.
module csat_checker
	import csat_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	csat_cfg_if    cfg,
	csat_req_if    req,
	csat_rsp_if    rsp,
	output int     errors,
	output int     pending
);

	typedef struct {
		logic [1:0]  status;
		logic        in_spill;
		logic [31:0] phys_address;
		logic [20:0] segment_bytes;
		logic [30:0] buffer_offset;
		logic        is_write;
		logic        last;
	} segment_t;

	segment_t segments_due[$];

	int unsigned file_chunks[MAX_FILES];
	logic [1:0]  map_loc[MAP_DEPTH];
	int unsigned map_phys[MAP_DEPTH];
	int unsigned mem_free[MAX_CHUNKS];
	int unsigned mem_top;
	int unsigned spill_free[SPILL_CHUNKS];
	int unsigned spill_top;
	logic [4:0]  size_log2;
	logic        mem_en;
	logic        spill_en;

	function automatic int unsigned eff_bits();
		if (size_log2 < SIZE_LOG2_MIN) return SIZE_LOG2_MIN;
		if (size_log2 > SIZE_LOG2_MAX) return SIZE_LOG2_MAX;
		return size_log2;
	endfunction

	function automatic void add_segment(logic [1:0] st, logic sp, longint phys,
			longint nbytes, longint boff, logic wr, logic lst);
		segment_t s;
		s.status = st;
		s.in_spill = sp;
		s.phys_address = phys[31:0];
		s.segment_bytes = nbytes[20:0];
		s.buffer_offset = boff[30:0];
		s.is_write = wr;
		s.last = lst;
		segments_due.push_back(s);
	endfunction

	function automatic bit take_chunk(int unsigned idx);
		if (mem_en && mem_top > 0) begin
			mem_top--;
			map_loc[idx] = LOC_MEM;
			map_phys[idx] = mem_free[mem_top];
			return 1;
		end
		if (spill_en && spill_top > 0) begin
			spill_top--;
			map_loc[idx] = LOC_SPILL;
			map_phys[idx] = spill_free[spill_top];
			return 1;
		end
		if (!mem_en && !spill_en)
			map_loc[idx] = LOC_NONE;
		return 0;
	endfunction

	function automatic void give_back(int unsigned idx);
		if (map_loc[idx] == LOC_MEM) begin
			if (mem_top < MAX_CHUNKS) mem_free[mem_top++] = map_phys[idx];
		end else if (map_loc[idx] == LOC_SPILL) begin
			if (spill_top < SPILL_CHUNKS) spill_free[spill_top++] = map_phys[idx];
		end else begin
			return;
		end
		map_loc[idx] = LOC_NONE;
	endfunction

	function automatic logic [1:0] grow_file(int unsigned fid, longint len, int unsigned bits);
		longint csz;
		longint need;
		csz = longint'(1) << bits;
		if (len <= (longint'(file_chunks[fid]) << bits)) return ST_OK;
		need = len - (longint'(file_chunks[fid]) << bits);
		while (need > 0) begin
			if (file_chunks[fid] >= MAX_CHUNKS) return ST_NOSPACE;
			if (!take_chunk(fid * MAX_CHUNKS + file_chunks[fid])) return ST_NOSPACE;
			file_chunks[fid]++;
			need = (need > csz) ? need - csz : 0;
		end
		return ST_OK;
	endfunction

	function automatic void translate_access(int unsigned fid, longint pos, longint cnt,
			logic wr, int unsigned bits);
		longint csz;
		longint cid;
		longint coff;
		longint seg;
		longint done;
		int n;
		bit more;
		int unsigned idx;
		csz = longint'(1) << bits;
		cid = pos >> bits;
		coff = pos & (csz - 1);
		seg = (cnt <= csz - coff) ? cnt : csz - coff;
		done = 0;
		n = 0;
		forever begin
			more = (done + seg) < cnt;
			if (cid >= MAX_CHUNKS) begin
				add_segment(ST_IOERR, 0, 0, 0, done, wr, 1);
				return;
			end
			idx = fid * MAX_CHUNKS + int'(cid);
			if (map_loc[idx] != LOC_MEM && map_loc[idx] != LOC_SPILL) begin
				add_segment(ST_IOERR, 0, 0, 0, done, wr, 1);
				return;
			end
			if (more && n == MAX_SEGMENTS - 1) begin
				add_segment(ST_TOOMANY, 0, 0, 0, done, wr, 1);
				return;
			end
			add_segment(ST_OK, map_loc[idx] == LOC_SPILL,
				(longint'(map_phys[idx]) << bits) + coff, seg, done, wr, !more);
			n++;
			if (!more) return;
			done += seg;
			cid++;
			coff = 0;
			seg = (cnt - done > csz) ? csz : cnt - done;
		end
	endfunction

	function automatic void apply_item(logic [1:0] op, int unsigned fid, longint pos, longint cnt);
		int unsigned bits;
		longint keep;
		bits = eff_bits();
		case (op)
			OP_EXTEND: add_segment(grow_file(fid, pos, bits), 0, 0, 0, 0, 0, 1);
			OP_SHRINK: begin
				keep = (pos > 0) ? (pos >> bits) + 1 : 0;
				while (longint'(file_chunks[fid]) > keep) begin
					file_chunks[fid]--;
					give_back(fid * MAX_CHUNKS + file_chunks[fid]);
				end
				add_segment(ST_OK, 0, 0, 0, 0, 0, 1);
			end
			default: translate_access(fid, pos, cnt, op == OP_WRITE, bits);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		segment_t e;
		if (!arst_n) begin
			foreach (file_chunks[i]) file_chunks[i] = 0;
			foreach (map_loc[i]) begin
				map_loc[i] = LOC_NONE;
				map_phys[i] = 0;
			end
			foreach (mem_free[i]) mem_free[i] = MAX_CHUNKS - 1 - i;
			foreach (spill_free[i]) spill_free[i] = SPILL_CHUNKS - 1 - i;
			mem_top = MAX_CHUNKS;
			spill_top = SPILL_CHUNKS;
			size_log2 = SIZE_LOG2_RST;
			mem_en = 1;
			spill_en = 0;
			segments_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SIZE_LOG2: size_log2 = cfg.data;
					CFG_MEM_EN:    mem_en = cfg.data[0];
					CFG_SPILL_EN:  spill_en = cfg.data[0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (segments_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected response status=%0d addr=%h", $time,
						rsp.status, rsp.phys_address);
				end else begin
					e = segments_due.pop_front();
					if (e.status !== rsp.status || e.in_spill !== rsp.in_spill ||
							e.phys_address !== rsp.phys_address ||
							e.segment_bytes !== rsp.segment_bytes ||
							e.buffer_offset !== rsp.buffer_offset ||
							e.is_write !== rsp.is_write || e.last !== rsp.last) begin
						errors++;
						$display("%0t: mismatch exp st=%0d sp=%0d addr=%h bytes=%0d off=%0d wr=%0d last=%0d",
							$time, e.status, e.in_spill, e.phys_address, e.segment_bytes,
							e.buffer_offset, e.is_write, e.last);
						$display("%0t:          got st=%0d sp=%0d addr=%h bytes=%0d off=%0d wr=%0d last=%0d",
							$time, rsp.status, rsp.in_spill, rsp.phys_address,
							rsp.segment_bytes, rsp.buffer_offset, rsp.is_write, rsp.last);
					end
				end
			end
			// request is predicted after the response pop so ordering holds
			if (req.valid && req.ready)
				apply_item(req.op, req.file_id, req.byte_position, req.byte_count);
			pending = segments_due.size();
		end
	end

endmodule

// File: sim/testbench.sv
// Testbench top: clock, reset, stimulus, idling phases and verdict.
module testbench;
	import csat_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	int   items_sent;
	int   send_idle;
	int   stall_pct;
	longint csz;

	csat_cfg_if cfg();
	csat_req_if req();
	csat_rsp_if rsp();

	chunk_store_allocator_translator_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp)
	);

	csat_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 10000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk)
		rsp.ready <= ($urandom_range(0, 99) >= stall_pct);

	task automatic write_reg(logic [1:0] index, logic [4:0] data);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.index <= index;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic send(logic [1:0] op, logic [3:0] fid, logic [30:0] pos, logic [30:0] cnt);
		case ((items_sent / 20) % 4)
			0: begin send_idle = 0;  stall_pct = 0;  end
			1: begin send_idle = 52; stall_pct = 0;  end
			2: begin send_idle = 0;  stall_pct = 52; end
			default: begin send_idle = 27; stall_pct = 27; end
		endcase
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.op <= op;
		req.file_id <= fid;
		req.byte_position <= pos;
		req.byte_count <= cnt;
		do @(posedge clk); while (!req.ready);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(logic [4:0] size_code, logic men, logic sen);
		write_reg(CFG_SIZE_LOG2, size_code);
		write_reg(CFG_MEM_EN, 5'(men));
		write_reg(CFG_SPILL_EN, 5'(sen));
		if (size_code < SIZE_LOG2_MIN) csz = longint'(1) << SIZE_LOG2_MIN;
		else if (size_code > SIZE_LOG2_MAX) csz = longint'(1) << SIZE_LOG2_MAX;
		else csz = longint'(1) << size_code;
	endtask

	// mostly in-range traffic on few chunks, with occasional full-width values
	task automatic random_items(int n);
		logic [1:0] op;
		longint pos;
		longint cnt;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			op = (r < 25) ? OP_EXTEND : (r < 40) ? OP_SHRINK : (r < 70) ? OP_READ : OP_WRITE;
			pos = ($urandom_range(0, 19) == 0) ? longint'($urandom) & 32'h7fffffff
				: csz * $urandom_range(0, 24) + $urandom_range(0, int'(csz) - 1);
			if (op == OP_SHRINK && $urandom_range(0, 5) == 0) pos = 0;
			cnt = ($urandom_range(0, 24) == 0) ? longint'($urandom) & 32'h7fffffff
				: ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, int'(csz) * 3);
			send(op, 4'($urandom_range(0, 15)), pos[30:0], cnt[30:0]);
		end
	endtask

	initial begin
		arst_n = 0;
		cycles = 0;
		items_sent = 0;
		send_idle = 0;
		stall_pct = 0;
		csz = 1 << 16;
		cfg.valid = 0;
		cfg.index = CFG_SIZE_LOG2;
		cfg.data = 0;
		req.valid = 0;
		req.op = OP_EXTEND;
		req.file_id = 0;
		req.byte_position = 0;
		req.byte_count = 0;
		rsp.ready = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset config: 64 KiB chunks, memory pool only
		send(OP_EXTEND, 0, 0, 31'h7fffffff);
		send(OP_EXTEND, 0, 200000, 0);
		send(OP_READ, 0, 0, 0);
		send(OP_READ, 0, 65530, 20);
		send(OP_WRITE, 0, 0, 200000);
		send(OP_READ, 0, 300000, 5);
		send(OP_READ, 0, 31'h7fffffff, 1);
		send(OP_SHRINK, 0, 70000, 31'h7fffffff);
		send(OP_READ, 0, 0, 300000);
		send(OP_EXTEND, 15, 31'h7fffffff, 0);
		send(OP_READ, 15, 100, 31'h7fffffff);
		send(OP_WRITE, 15, 31'h7fff0000, 16);
		send(OP_EXTEND, 3, 10, 0);
		send(OP_SHRINK, 15, 0, 0);
		send(OP_EXTEND, 3, 10, 0);
		send(OP_SHRINK, 0, 0, 0);
		send(OP_SHRINK, 3, 0, 0);
		drain();

		// both pools disabled: any extend that needs a chunk fails
		configure(5'd10, 0, 0);
		send(OP_EXTEND, 7, 5000, 0);
		send(OP_READ, 7, 0, 10);
		random_items(20);
		drain();

		configure(5'd4, 1, 1);
		send(OP_EXTEND, 9, 31'h7fffffff, 0);
		send(OP_WRITE, 9, 0, 2000);
		random_items(80);
		drain();
		configure(5'd20, 0, 1);
		random_items(70);
		drain();
		configure(5'd31, 1, 1);
		random_items(60);
		drain();
		configure(5'd0, 1, 0);
		random_items(60);
		drain();
		configure(5'd12, 1, 1);
		random_items(95);
		drain();

		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
sv/csat_pkg.sv
sv/csat_if.sv
sv/csat_map.sv
sv/csat_pool.sv
sv/chunk_store_allocator_translator_top.sv
sim/csat_checker.sv
sim/testbench.sv
